[rtl/ibt_pkg.sv]
// Shared constants and types for the interval booking table.
package ibt_pkg;

    // Table geometry and time field width.
    localparam int TABLE_DEPTH = 64;
    localparam int TIME_BITS   = 30;
    localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);

    // Stream payload widths, padded to whole bytes.
    localparam int IN_DATA_BITS  = ((2 * TIME_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = 8;

    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [CNT_BITS-1:0]  count_t;

    // Controls broadcast from the sequencer to every cell.
    typedef struct packed {
        logic compare;  // register this cell's overlap flag
        logic shift;    // take the neighbor's entry
    } cell_ctrl_t;

endpackage

[rtl/interval_booking_table_unit.sv]
// Top level of the interval booking table: sequencer, cell row and result register.
//
//  channel | dir | fields (lowest bit first)           | accepted when
//  s_*     | in  | interval_start, interval_end        | s_tvalid && s_tready
//  m_*     | out | accepted, table_full                | m_tvalid && m_tready
//
// Each request passes through a compare state, in which every cell registers its
// overlap flag, and a resolve state, in which the flags are OR-reduced and the
// result is written. A new request is taken in the resolve state of the previous
// one. Reset clears the fill count, the output valid flag and the sequencer; the
// stored intervals are not cleared. A stalled output holds the sequencer in the
// resolve state until the result register is free.
module interval_booking_table_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // s_tdata: interval_start, interval_end, zero padding
    input  logic [ibt_pkg::IN_DATA_BITS-1:0]   s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // m_tdata: accepted, table_full, zero padding
    output logic [ibt_pkg::OUT_DATA_BITS-1:0]  m_tdata
);

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_COMPARE = 2'd1;
    localparam logic [1:0] ST_RESOLVE = 2'd2;

    logic [1:0]          state_reg;
    logic [1:0]          state_next;
    ibt_pkg::time_t      req_start_reg;
    ibt_pkg::time_t      req_end_reg;
    ibt_pkg::count_t     fill_reg;
    ibt_pkg::count_t     fill_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                accepted_reg;
    logic                accepted_next;
    logic                full_reg;
    logic                full_next;
    logic                in_take;
    logic                out_free;
    logic                emit;
    logic                any_hit;
    logic                table_is_full;
    ibt_pkg::cell_ctrl_t ctrl;

    ibt_pkg::time_t                    cell_start [ibt_pkg::TABLE_DEPTH];
    ibt_pkg::time_t                    cell_end   [ibt_pkg::TABLE_DEPTH];
    logic [ibt_pkg::TABLE_DEPTH-1:0]   cell_hit;

    assign out_free      = !out_valid_reg || m_tready;
    assign s_tready      = (state_reg == ST_IDLE) || ((state_reg == ST_RESOLVE) && out_free);
    assign in_take       = s_tvalid && s_tready;
    assign emit          = (state_reg == ST_RESOLVE) && out_free;
    assign any_hit       = |cell_hit;
    assign table_is_full = (fill_reg == ibt_pkg::count_t'(ibt_pkg::TABLE_DEPTH));

    // Cell controls: compare in the cycle after a request is taken, append on resolve.
    assign ctrl.compare = (state_reg == ST_COMPARE);
    assign ctrl.shift   = emit && !any_hit && !table_is_full;

    // Sequencer and result decision.
    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        out_valid_next = out_valid_reg && !m_tready;
        accepted_next  = accepted_reg;
        full_next      = full_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    state_next = ST_COMPARE;
                end
            end
            ST_COMPARE:
            begin
                state_next = ST_RESOLVE;
            end
            ST_RESOLVE:
            begin
                if (emit)
                begin
                    out_valid_next = 1'b1;
                    accepted_next  = !any_hit && !table_is_full;
                    full_next      = !any_hit && table_is_full;
                    if (ctrl.shift)
                    begin
                        fill_next = fill_reg + 1'b1;
                    end
                    state_next = in_take ? ST_COMPARE : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: the request under test and the pending result.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            req_start_reg <= s_tdata[ibt_pkg::TIME_BITS-1:0];
            req_end_reg   <= s_tdata[2*ibt_pkg::TIME_BITS-1:ibt_pkg::TIME_BITS];
        end
        accepted_reg <= accepted_next;
        full_reg     <= full_next;
    end

    // Row of cells; a new interval enters cell zero and older ones move down.
    for (genvar i = 0; i < ibt_pkg::TABLE_DEPTH; i++)
    begin : g_cell
        ibt_pkg::time_t prev_start;
        ibt_pkg::time_t prev_end;
        logic           cell_valid;

        if (i == 0)
        begin : g_head
            assign prev_start = req_start_reg;
            assign prev_end   = req_end_reg;
        end
        else
        begin : g_body
            assign prev_start = cell_start[i-1];
            assign prev_end   = cell_end[i-1];
        end

        assign cell_valid = (fill_reg > ibt_pkg::count_t'(i));

        ibt_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .valid      (cell_valid),
            .req_start  (req_start_reg),
            .req_end    (req_end_reg),
            .prev_start (prev_start),
            .prev_end   (prev_end),
            .start_out  (cell_start[i]),
            .end_out    (cell_end[i]),
            .hit        (cell_hit[i])
        );
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(ibt_pkg::OUT_DATA_BITS - 2){1'b0}}, full_reg, accepted_reg};

endmodule

[rtl/ibt_cell.sv]
// One table cell: holds an interval, tests it against the request, and shifts on append.
module ibt_cell (
    input  logic                clk,
    input  ibt_pkg::cell_ctrl_t ctrl,
    input  logic                valid,
    input  ibt_pkg::time_t      req_start,
    input  ibt_pkg::time_t      req_end,
    input  ibt_pkg::time_t      prev_start,
    input  ibt_pkg::time_t      prev_end,
    output ibt_pkg::time_t      start_out,
    output ibt_pkg::time_t      end_out,
    output logic                hit
);

    ibt_pkg::time_t start_reg;
    ibt_pkg::time_t end_reg;
    logic           hit_reg;
    ibt_pkg::time_t hi_start;
    ibt_pkg::time_t lo_end;
    logic           hit_next;

    // Two intervals overlap when the later start lies before the earlier end.
    always_comb
    begin
        hi_start = (start_reg > req_start) ? start_reg : req_start;
        lo_end   = (end_reg < req_end) ? end_reg : req_end;
        hit_next = valid && (hi_start < lo_end);
    end

    // The entry moves one cell down the row whenever a new interval is appended.
    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            start_reg <= prev_start;
            end_reg   <= prev_end;
        end
        if (ctrl.compare)
        begin
            hit_reg <= hit_next;
        end
    end

    assign start_out = start_reg;
    assign end_out   = end_reg;
    assign hit       = hit_reg;

endmodule
